/* design/sfa_pkg.sv */
// Shared constants and types for the self-fed automaton sequence generator.
`timescale 1ns / 1ps

package sfa_pkg;

  localparam int NUM_STATES  = 16;
  localparam int NUM_SYMBOLS = 2;
  localparam int QUEUE_DEPTH = 64;

  localparam int ST_W      = $clog2(NUM_STATES);
  localparam int SYM_W     = 1;
  localparam int TAB_DEPTH = NUM_STATES * NUM_SYMBOLS;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);
  localparam int Q_AW      = $clog2(QUEUE_DEPTH);
  localparam int PTR_W     = Q_AW + 1;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_EMIT    = 2'd2;

  typedef struct packed {
    logic [ST_W-1:0] next_state;
    logic            two;
    logic            r1;
    logic            r0;
  } tab_entry_t;

  localparam int TAB_W = $bits(tab_entry_t);

  typedef struct packed {
    logic            we;
    logic [Q_AW-1:0] waddr;
    logic            wdata;
    logic [Q_AW-1:0] raddr;
  } q_req_t;

  typedef struct packed {
    logic              we;
    logic [TAB_AW-1:0] waddr;
    tab_entry_t        wdata;
    logic [TAB_AW-1:0] raddr;
  } tab_req_t;

  typedef struct packed {
    logic valid;
    logic sym;
    logic status;
  } res_t;

endpackage

/* design/sfa_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps

module sfa_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/sfa_seq.sv */
// Command sequencer: pointers, automaton state and memory access ordering.
`timescale 1ns / 1ps

module sfa_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic                      seed_symbol,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                command,
  input  logic [3:0]                entry_state,
  input  logic                      entry_symbol,
  input  logic [3:0]                entry_next_state,
  input  logic [1:0]                entry_response_count,
  input  logic                      entry_response_first,
  input  logic                      entry_response_second,
  output sfa_pkg::q_req_t           q_req,
  input  logic                      q_rdata,
  output sfa_pkg::tab_req_t         tab_req,
  input  sfa_pkg::tab_entry_t       tab_rdata,
  output sfa_pkg::res_t             res,
  input  logic                      res_ready
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_EMIT_RD = 3'd1;
  localparam logic [2:0] ST_CONS_RD = 3'd2;
  localparam logic [2:0] ST_TAB_RD  = 3'd3;
  localparam logic [2:0] ST_PUSH2   = 3'd4;
  localparam logic [2:0] ST_RESP    = 3'd5;

  logic [2:0]                       fsm;
  logic [sfa_pkg::ST_W-1:0]         cur_state;
  logic [sfa_pkg::PTR_W-1:0]        wp;
  logic [sfa_pkg::PTR_W-1:0]        ep;
  logic [sfa_pkg::PTR_W-1:0]        cp;
  logic                             seed;
  logic                             res_sym;
  logic                             res_status;
  logic                             r1_hold;

  logic                             accept;
  logic [sfa_pkg::PTR_W-1:0]        held;
  logic                             ovf;
  logic                             load_ok;

  assign accept   = in_valid && in_ready;
  assign in_ready = (fsm == ST_IDLE);
  assign held     = wp - cp;
  assign ovf      = (held == sfa_pkg::PTR_W'(sfa_pkg::QUEUE_DEPTH)) && tab_rdata.two;
  assign load_ok  = (int'(entry_state) < sfa_pkg::NUM_STATES) &&
                    (int'(entry_symbol) < sfa_pkg::NUM_SYMBOLS);

  assign res.valid  = (fsm == ST_RESP);
  assign res.sym    = res_sym;
  assign res.status = res_status;

  always_comb begin
    q_req.we    = 1'b0;
    q_req.waddr = wp[sfa_pkg::Q_AW-1:0];
    q_req.wdata = 1'b0;
    q_req.raddr = ep[sfa_pkg::Q_AW-1:0];

    tab_req.we               = 1'b0;
    tab_req.waddr            = sfa_pkg::TAB_AW'(
                                 sfa_pkg::TAB_AW'(entry_state) *
                                 sfa_pkg::TAB_AW'(sfa_pkg::NUM_SYMBOLS) +
                                 sfa_pkg::TAB_AW'(entry_symbol));
    tab_req.wdata.next_state = sfa_pkg::ST_W'(entry_next_state);
    tab_req.wdata.two        = (entry_response_count >= 2'd2);
    tab_req.wdata.r1         = entry_response_second;
    tab_req.wdata.r0         = entry_response_first;
    tab_req.raddr            = sfa_pkg::TAB_AW'(
                                 sfa_pkg::TAB_AW'(cur_state) *
                                 sfa_pkg::TAB_AW'(sfa_pkg::NUM_SYMBOLS) +
                                 sfa_pkg::TAB_AW'(q_rdata));

    case (fsm)
      ST_IDLE: begin
        if (accept) begin
          case (command)
            sfa_pkg::CMD_LOAD: begin
              tab_req.we = load_ok;
            end
            sfa_pkg::CMD_RESTART: begin
              q_req.we    = 1'b1;
              q_req.waddr = '0;
              q_req.wdata = seed;
            end
            sfa_pkg::CMD_EMIT: begin
              // nothing left to emit: fetch the oldest unconsumed symbol
              if (ep == wp) begin
                q_req.raddr = cp[sfa_pkg::Q_AW-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_TAB_RD: begin
        q_req.we    = !ovf;
        q_req.wdata = tab_rdata.r0;
      end
      ST_PUSH2: begin
        q_req.we    = 1'b1;
        q_req.wdata = r1_hold;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm        <= ST_IDLE;
      cur_state  <= '0;
      wp         <= '0;
      ep         <= '0;
      cp         <= '0;
      seed       <= 1'b0;
      res_sym    <= 1'b0;
      res_status <= 1'b0;
      r1_hold    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        seed <= seed_symbol;
      end
      case (fsm)
        ST_IDLE: begin
          if (accept) begin
            res_sym    <= 1'b0;
            res_status <= (command == sfa_pkg::CMD_EMIT) && (ep == wp) && (cp == wp);
            case (command)
              sfa_pkg::CMD_RESTART: begin
                cur_state <= '0;
                wp        <= sfa_pkg::PTR_W'(1);
                ep        <= '0;
                cp        <= '0;
                fsm       <= ST_RESP;
              end
              sfa_pkg::CMD_EMIT: begin
                if (ep != wp) begin
                  fsm <= ST_EMIT_RD;
                end else if (cp == wp) begin
                  fsm <= ST_RESP;
                end else begin
                  fsm <= ST_CONS_RD;
                end
              end
              default: begin
                fsm <= ST_RESP;
              end
            endcase
          end
        end
        ST_EMIT_RD: begin
          res_sym <= q_rdata;
          ep      <= ep + 1'b1;
          fsm     <= ST_RESP;
        end
        ST_CONS_RD: begin
          fsm <= ST_TAB_RD;
        end
        ST_TAB_RD: begin
          if (ovf) begin
            res_status <= 1'b1;
            fsm        <= ST_RESP;
          end else begin
            // the emitted symbol is the first response just appended
            res_sym   <= tab_rdata.r0;
            cp        <= cp + 1'b1;
            wp        <= wp + 1'b1;
            ep        <= ep + 1'b1;
            cur_state <= tab_rdata.next_state;
            r1_hold   <= tab_rdata.r1;
            fsm       <= tab_rdata.two ? ST_PUSH2 : ST_RESP;
          end
        end
        ST_PUSH2: begin
          wp  <= wp + 1'b1;
          fsm <= ST_RESP;
        end
        ST_RESP: begin
          if (res_ready) begin
            fsm <= ST_IDLE;
          end
        end
        default: begin
          fsm <= ST_IDLE;
        end
      endcase
    end
  end

  a_res_slot_free: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res_ready |=> res.valid && $stable(res_sym) && $stable(res_status))
    else $error("result dropped while output slot busy");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    held <= sfa_pkg::PTR_W'(sfa_pkg::QUEUE_DEPTH))
    else $error("pending queue holds more than its depth");

  a_emit_window: assert property (@(posedge clk) disable iff (rst)
    sfa_pkg::PTR_W'(ep - cp) <= held)
    else $error("emit pointer outside kept window");

  a_consume_step: assert property (@(posedge clk) disable iff (rst)
    (fsm == ST_TAB_RD) && !ovf |=> cp == $past(cp) + 1'b1)
    else $error("consume pointer did not advance");

endmodule

/* design/self_fed_automaton_sequence_generator.sv */
// Top level: sequencer, queue and table memories, and the output register.
//
// Each input item is one command. A load, a restart or any unused command goes
// straight from acceptance to the result state. An emit makes one queue read
// when a written symbol is waiting; when it has to consume a symbol first, it
// makes a queue read, then a dependent table read, then one or two appends
// through the single queue write port. The result sits in an output register,
// so the next item can be taken while it waits. Both memories are undefined
// after reset and need no clearing.
`timescale 1ns / 1ps

module self_fed_automaton_sequence_generator (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       seed_symbol,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  logic [3:0] entry_state,
  input  logic       entry_symbol,
  input  logic [3:0] entry_next_state,
  input  logic [1:0] entry_response_count,
  input  logic       entry_response_first,
  input  logic       entry_response_second,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_symbol,
  output logic       status
);

  sfa_pkg::q_req_t     q_req;
  logic                q_rdata;
  sfa_pkg::tab_req_t   tab_req;
  sfa_pkg::tab_entry_t tab_rdata;
  logic [sfa_pkg::TAB_W-1:0] tab_rbits;
  sfa_pkg::res_t       res;
  logic                res_ready;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid || out_ready;
  assign tab_rdata = sfa_pkg::tab_entry_t'(tab_rbits);

  sfa_seq u_seq (
    .clk                   (clk),
    .rst                   (rst),
    .cfg_valid             (cfg_valid),
    .seed_symbol           (seed_symbol),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .command               (command),
    .entry_state           (entry_state),
    .entry_symbol          (entry_symbol),
    .entry_next_state      (entry_next_state),
    .entry_response_count  (entry_response_count),
    .entry_response_first  (entry_response_first),
    .entry_response_second (entry_response_second),
    .q_req                 (q_req),
    .q_rdata               (q_rdata),
    .tab_req               (tab_req),
    .tab_rdata             (tab_rdata),
    .res                   (res),
    .res_ready             (res_ready)
  );

  sfa_ram #(
    .DEPTH (sfa_pkg::QUEUE_DEPTH),
    .WIDTH (1)
  ) u_queue (
    .clk   (clk),
    .we    (q_req.we),
    .waddr (q_req.waddr),
    .wdata (q_req.wdata),
    .raddr (q_req.raddr),
    .rdata (q_rdata)
  );

  sfa_ram #(
    .DEPTH (sfa_pkg::TAB_DEPTH),
    .WIDTH (sfa_pkg::TAB_W)
  ) u_table (
    .clk   (clk),
    .we    (tab_req.we),
    .waddr (tab_req.waddr),
    .wdata (tab_req.wdata),
    .raddr (tab_req.raddr),
    .rdata (tab_rbits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_symbol <= res.sym;
      status     <= res.status;
    end
  end

endmodule

/* test/tb_self_fed_automaton_sequence_generator.sv */
// Testbench for the self-fed automaton sequence generator: directed and random commands.
`timescale 1ns / 1ps

module tb_self_fed_automaton_sequence_generator;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 180;
  localparam int RX_HOLD      = 300;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [1:0]               command;
    logic [sfa_pkg::ST_W-1:0] state_idx;
    logic                     sym_idx;
    logic [sfa_pkg::ST_W-1:0] next_st;
    logic [1:0]               count;
    logic                     r_first;
    logic                     r_second;
  } cmd_item_t;

  typedef struct packed {
    logic sym;
    logic stat;
  } out_item_t;

  // Tracks the automaton, its table and its symbol queue; predicts each output item.
  class automaton_scoreboard;
    logic [sfa_pkg::ST_W-1:0]  next_tab [sfa_pkg::TAB_DEPTH];
    logic [2:0]                resp_tab [sfa_pkg::TAB_DEPTH];
    bit                        loaded   [sfa_pkg::TAB_DEPTH];
    bit                        fifo     [sfa_pkg::QUEUE_DEPTH];
    logic [sfa_pkg::ST_W-1:0]  state_q;
    logic [sfa_pkg::PTR_W-1:0] wr_ptr, emit_ptr, cons_ptr;
    bit                        seed;
    out_item_t                 expected_out[$];
    int                        errors;

    function new();
      state_q  = '0;
      wr_ptr   = '0;
      emit_ptr = '0;
      cons_ptr = '0;
      seed     = 1'b0;
      errors   = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function void push_sym(bit v);
      fifo[wr_ptr[sfa_pkg::Q_AW-1:0]] = v;
      wr_ptr++;
    endfunction

    // Table index the next emit would consume from if it is still unloaded, else -1.
    function int missing_entry();
      logic [sfa_pkg::TAB_AW-1:0] idx;
      if (emit_ptr != wr_ptr || wr_ptr == cons_ptr) return -1;
      idx = {state_q, fifo[cons_ptr[sfa_pkg::Q_AW-1:0]]};
      return loaded[idx] ? -1 : int'(idx);
    endfunction

    function void note_command(cmd_item_t it);
      out_item_t                  r;
      logic [sfa_pkg::TAB_AW-1:0] idx;
      logic [sfa_pkg::PTR_W-1:0]  held;
      bit                         two;
      r = '0;
      case (it.command)
        sfa_pkg::CMD_LOAD: begin
          idx = {it.state_idx, it.sym_idx};
          next_tab[idx] = it.next_st;
          resp_tab[idx] = {it.count >= 2'd2, it.r_second, it.r_first};
          loaded[idx]   = 1'b1;
        end
        sfa_pkg::CMD_RESTART: begin
          state_q  = '0;
          wr_ptr   = '0;
          emit_ptr = '0;
          cons_ptr = '0;
          push_sym(seed);
        end
        sfa_pkg::CMD_EMIT: begin
          held = wr_ptr - cons_ptr;
          if (emit_ptr == wr_ptr) begin
            if (held == 0) begin
              r.stat = 1'b1;
            end else begin
              idx = {state_q, fifo[cons_ptr[sfa_pkg::Q_AW-1:0]]};
              two = resp_tab[idx][2];
              // consuming frees one slot, the responses take one or two
              if (int'(held) - 1 + (two ? 2 : 1) > sfa_pkg::QUEUE_DEPTH) begin
                r.stat = 1'b1;
              end else begin
                cons_ptr++;
                push_sym(resp_tab[idx][0]);
                if (two) push_sym(resp_tab[idx][1]);
                state_q = next_tab[idx];
              end
            end
          end
          if (!r.stat) begin
            r.sym = fifo[emit_ptr[sfa_pkg::Q_AW-1:0]];
            emit_ptr++;
          end
        end
        default: ;
      endcase
      expected_out = {expected_out, r};
    endfunction

    function void check_output(logic sym, logic stat);
      out_item_t e;
      if (expected_out.size() == 0) begin
        $error("out item with nothing expected: out_symbol %0d status %0d", sym, stat);
        errors++;
        return;
      end
      e = expected_out.pop_front();
      if (sym !== e.sym) begin
        $error("out_symbol: expected %0d, actual %0d", e.sym, sym);
        errors++;
      end
      if (stat !== e.stat) begin
        $error("status: expected %0d, actual %0d", e.stat, stat);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       seed_symbol = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] command = sfa_pkg::CMD_LOAD;
  logic [3:0] entry_state = '0;
  logic       entry_symbol = 1'b0;
  logic [3:0] entry_next_state = '0;
  logic [1:0] entry_response_count = 2'd1;
  logic       entry_response_first = 1'b0;
  logic       entry_response_second = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_symbol;
  logic       status;

  automaton_scoreboard sb;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_req = 1'b0;
  int sent_items = 0;

  self_fed_automaton_sequence_generator uut (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .seed_symbol          (seed_symbol),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .command              (command),
    .entry_state          (entry_state),
    .entry_symbol         (entry_symbol),
    .entry_next_state     (entry_next_state),
    .entry_response_count (entry_response_count),
    .entry_response_first (entry_response_first),
    .entry_response_second(entry_response_second),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_symbol           (out_symbol),
    .status               (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic cmd_item_t random_fields(logic [1:0] cmd, bit grow);
    cmd_item_t it;
    it.command   = cmd;
    it.state_idx = sfa_pkg::ST_W'($urandom_range(0, sfa_pkg::NUM_STATES - 1));
    it.sym_idx   = 1'($urandom_range(0, 1));
    it.next_st   = sfa_pkg::ST_W'($urandom_range(0, sfa_pkg::NUM_STATES - 1));
    it.count     = grow ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 3));
    it.r_first   = 1'($urandom_range(0, 1));
    it.r_second  = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic cmd_item_t load_item(int st, int sy, int nx, int cnt, int r0, int r1);
    cmd_item_t it;
    it.command   = sfa_pkg::CMD_LOAD;
    it.state_idx = sfa_pkg::ST_W'(st);
    it.sym_idx   = 1'(sy);
    it.next_st   = sfa_pkg::ST_W'(nx);
    it.count     = 2'(cnt);
    it.r_first   = 1'(r0);
    it.r_second  = 1'(r1);
    return it;
  endfunction

  task automatic send(cmd_item_t it);
    int n;
    n = (tx_idle && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid              <= 1'b1;
    command               <= it.command;
    entry_state           <= it.state_idx;
    entry_symbol          <= it.sym_idx;
    entry_next_state      <= it.next_st;
    entry_response_count  <= it.count;
    entry_response_first  <= it.r_first;
    entry_response_second <= it.r_second;
    do @(posedge clk); while (!in_ready);
    sb.note_command(it);
    if (it.command != CMD_UNUSED) sent_items++;
  endtask

  // An emit never consumes through an unloaded table entry: load it first.
  task automatic issue(cmd_item_t it, bit grow);
    cmd_item_t ld;
    int idx;
    idx = sb.missing_entry();
    if (it.command == sfa_pkg::CMD_EMIT && idx >= 0) begin
      ld = random_fields(sfa_pkg::CMD_LOAD, grow);
      ld.state_idx = sfa_pkg::ST_W'(idx / sfa_pkg::NUM_SYMBOLS);
      ld.sym_idx   = 1'(idx % sfa_pkg::NUM_SYMBOLS);
      send(ld);
    end
    send(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_out.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(bit v);
    cfg_valid   <= 1'b1;
    seed_symbol <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.seed = v;
  endtask

  initial begin : stimulus
    int         target;
    int         roll;
    bit         grow;
    bit         paused;
    logic [1:0] cmd;
    cmd_item_t  it;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    write_seed(1'b1);
    // emit before any restart: nothing to emit
    issue(random_fields(sfa_pkg::CMD_EMIT, 1'b0), 1'b0);
    issue(random_fields(CMD_UNUSED, 1'b0), 1'b0);
    // count 0 acts as one response, 3 as two
    issue(load_item(0, 0, 15, 0, 1, 1), 1'b0);
    issue(load_item(0, 1, 15, 3, 0, 1), 1'b0);
    issue(load_item(15, 0, 0, 2, 1, 0), 1'b0);
    issue(load_item(15, 1, 0, 1, 0, 1), 1'b0);
    issue(random_fields(sfa_pkg::CMD_RESTART, 1'b0), 1'b0);
    repeat (8) issue(random_fields(sfa_pkg::CMD_EMIT, 1'b0), 1'b0);
    issue(random_fields(sfa_pkg::CMD_RESTART, 1'b0), 1'b0);
    repeat (2) issue(random_fields(sfa_pkg::CMD_EMIT, 1'b0), 1'b0);
    issue(random_fields(CMD_UNUSED, 1'b0), 1'b0);
    repeat (2) issue(random_fields(sfa_pkg::CMD_EMIT, 1'b0), 1'b0);

    paused = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      // growth phases load two-response entries so the queue runs into overflow
      grow = (p % 3 == 1);
      wait_idle();
      write_seed(1'(p % 2));
      tx_idle = (p != 1) && (p % 4 != 3);
      rx_idle = (p % 4 != 2);
      if (p == 1) hold_req = 1'b1;
      if (grow) begin
        for (int i = 0; i < sfa_pkg::TAB_DEPTH; i++) begin
          it = random_fields(sfa_pkg::CMD_LOAD, 1'b1);
          it.state_idx = sfa_pkg::ST_W'(i / sfa_pkg::NUM_SYMBOLS);
          it.sym_idx   = 1'(i % sfa_pkg::NUM_SYMBOLS);
          issue(it, 1'b1);
        end
        issue(random_fields(sfa_pkg::CMD_RESTART, 1'b1), 1'b1);
      end
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) begin
        if (p == 3 && !paused && sent_items >= target - PHASE_ITEMS / 2) begin
          paused = 1'b1;
          wait_idle();
        end
        roll = $urandom_range(0, 199);
        if (grow)
          cmd = (roll < 1) ? sfa_pkg::CMD_RESTART : (roll < 7) ? sfa_pkg::CMD_LOAD :
                (roll < 9) ? CMD_UNUSED : sfa_pkg::CMD_EMIT;
        else
          cmd = (roll < 10) ? sfa_pkg::CMD_RESTART : (roll < 40) ? sfa_pkg::CMD_LOAD :
                (roll < 50) ? CMD_UNUSED : sfa_pkg::CMD_EMIT;
        issue(random_fields(cmd, grow), grow);
      end
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("self_fed_automaton_sequence_generator: match");
    end else begin
      $display("self_fed_automaton_sequence_generator: mismatch");
    end
    $finish;
  end

  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      n = 0;
      if (hold_req) begin
        hold_req = 1'b0;
        n = RX_HOLD;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        n = gap_len();
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_output(out_symbol, status);
  end

  initial begin : watchdog
    #2_000_000;
    $display("self_fed_automaton_sequence_generator: mismatch");
    $finish;
  end

endmodule
